/* design/ffisa_pkg.sv */
// ----------------------------------------------------------------------------
// ffisa_pkg: shared types and constants of the first-fit slot allocator
// Holds the request and response word layouts, the slot count and the
// widths derived from it, and the record passed from the slot picker.
// ----------------------------------------------------------------------------
package ffisa_pkg;

   // Number of slots that can be opened.
   localparam int MAX_SLOTS = 10;

   // Field widths fixed by the word layouts.
   localparam int START_W  = 17;
   localparam int LENGTH_W = 14;
   localparam int SLOT_W   = 4;

   // A finish time holds start plus length without wrapping.
   localparam int FINISH_W = 18;

   // The open count runs from zero up to and including MAX_SLOTS.
   localparam int COUNT_W = $clog2(MAX_SLOTS + 1);

   typedef logic [FINISH_W-1:0] finish_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   // Request word: one interval to place.
   typedef struct packed {
      logic [START_W-1:0]  start_minute;
      logic [LENGTH_W-1:0] length_minutes;
   } req_word_type;

   // Response word: the outcome for one request.
   typedef struct packed {
      logic     granted;
      slot_type slot_index;
      logic     opened_new;
   } rsp_word_type;

   // Decision from the slot picker.
   typedef struct packed {
      logic     reuse;  // an opened slot is free
      logic     fresh;  // no opened slot is free and a new one can be opened
      slot_type pick;   // slot that takes the request
   } pick_type;

endpackage

/* design/ffisa_pick.sv */
// ----------------------------------------------------------------------------
// ffisa_pick: first-fit slot picker
// Compares the start time with the finish time of every opened slot in
// parallel and priority-encodes the lowest free one; falls back to the next
// unused slot while there is room.
// ----------------------------------------------------------------------------
module ffisa_pick (
   input  ffisa_pkg::finish_type [ffisa_pkg::MAX_SLOTS-1:0] slot_finish,
   input  ffisa_pkg::count_type                             open_count,
   input  logic [ffisa_pkg::START_W-1:0]                    start_minute,
   output ffisa_pkg::pick_type                              decision
);

   logic [ffisa_pkg::MAX_SLOTS-1:0] free;
   ffisa_pkg::finish_type           start_ext;
   ffisa_pkg::slot_type             low_free;

   assign start_ext = ffisa_pkg::finish_type'(start_minute);

   // A slot is free when it is opened and its finish time is not after the start.
   always_comb begin
      for (int i = 0; i < ffisa_pkg::MAX_SLOTS; i++) begin
         free[i] = (ffisa_pkg::count_type'(i) < open_count) && (slot_finish[i] <= start_ext);
      end
   end

   // Priority encoder: the lowest-numbered free slot wins.
   always_comb begin
      low_free = '0;
      for (int i = ffisa_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
         if (free[i]) begin
            low_free = ffisa_pkg::slot_type'(i);
         end
      end
   end

   // Reuse a free slot, else open the next one if the table is not full.
   always_comb begin
      decision.reuse = |free;
      decision.fresh = !(|free) &&
                       (open_count < ffisa_pkg::count_type'(ffisa_pkg::MAX_SLOTS));
      if (|free) begin
         decision.pick = low_free;
      end else begin
         decision.pick = ffisa_pkg::slot_type'(open_count);
      end
   end

endmodule

/* design/first_fit_interval_slot_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_interval_slot_allocator: first-fit interval slot allocator
// Places each requested interval in the lowest-numbered opened slot that is
// free at its start time, opening a new slot when none is free.
// ----------------------------------------------------------------------------
// The block takes one request word per clock cycle while req_stall is low
// and returns one response word per request, in order. A request is
// captured in an input register, decided from it by the slot picker and
// the finish-time adder, and its response is shown from the output
// register. It keeps one word per cycle while not stalled, through the
// parallel finish-time compares, the priority encoder and the finish-time
// adder over the slot registers. A response that is stalled does not stop
// the input register from taking one more request. After reset all slots
// are closed with finish time zero.
module first_fit_interval_slot_allocator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ffisa_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ffisa_pkg::rsp_word_type rsp_word
);

   logic                    in_valid_ff;
   ffisa_pkg::req_word_type in_word_ff;
   logic                    out_valid_ff;
   ffisa_pkg::rsp_word_type out_word_ff;
   ffisa_pkg::rsp_word_type out_word_in;

   ffisa_pkg::finish_type [ffisa_pkg::MAX_SLOTS-1:0] slot_finish_ff;
   ffisa_pkg::finish_type [ffisa_pkg::MAX_SLOTS-1:0] slot_finish_in;
   ffisa_pkg::count_type                             open_count_ff;
   ffisa_pkg::count_type                             open_count_in;

   ffisa_pkg::pick_type   decision;
   ffisa_pkg::finish_type end_minute;
   logic                  advance;
   logic                  granted;

   // The held request moves on when the output register is empty or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   ffisa_pick u_pick (
      .slot_finish  (slot_finish_ff),
      .open_count   (open_count_ff),
      .start_minute (in_word_ff.start_minute),
      .decision     (decision)
   );

   // Candidate finish time of the request.
   assign end_minute = ffisa_pkg::finish_type'(in_word_ff.start_minute) +
                       ffisa_pkg::finish_type'(in_word_ff.length_minutes);
   assign granted    = decision.reuse || decision.fresh;

   // Next slot state: the chosen slot keeps the later of its finish times.
   always_comb begin
      slot_finish_in = slot_finish_ff;
      open_count_in  = open_count_ff;
      if (advance && granted) begin
         for (int i = 0; i < ffisa_pkg::MAX_SLOTS; i++) begin
            if ((decision.pick == ffisa_pkg::slot_type'(i)) &&
                (end_minute > slot_finish_ff[i])) begin
               slot_finish_in[i] = end_minute;
            end
         end
      end
      if (advance && decision.fresh) begin
         open_count_in = open_count_ff + ffisa_pkg::count_type'(1);
      end
   end

   // Slot state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_finish_ff <= '0;
         open_count_ff  <= '0;
      end else begin
         slot_finish_ff <= slot_finish_in;
         open_count_ff  <= open_count_in;
      end
   end

   // Response word; a rejected request reports slot zero.
   always_comb begin
      out_word_in.granted    = granted;
      out_word_in.slot_index = granted ? decision.pick : '0;
      out_word_in.opened_new = decision.fresh;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

/* design/ffisa_checker.sv */
// ----------------------------------------------------------------------------
// ffisa_checker: port checks of the first-fit slot allocator
// Watches the top level's ports for response consistency and handshake rules.
// ----------------------------------------------------------------------------
module ffisa_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input ffisa_pkg::req_word_type req_word,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input ffisa_pkg::rsp_word_type rsp_word
);

   // A stalled request word stays and does not change.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("request word changed while stalled");

   // A stalled response word stays and does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // A rejected request reports slot zero and no new slot.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.granted |-> rsp_word.slot_index == '0 && !rsp_word.opened_new)
      else $error("rejected response carries a slot");

   // A granted slot number is within the slot table.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.granted |->
         rsp_word.slot_index < ffisa_pkg::slot_type'(ffisa_pkg::MAX_SLOTS))
      else $error("granted slot out of range");

   // No response word appears in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind first_fit_interval_slot_allocator ffisa_checker u_ffisa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the first-fit interval slot allocator
// Drives request words with random idle gaps and response stalls. A
// scoreboard keeps its own copy of the slot finish times and the open count,
// predicts the grant for every accepted request, and checks the responses in
// order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 600000;

   // Tracks slot occupancy and holds the grants that are still owed.
   class interval_grant_tracker;
      ffisa_pkg::finish_type   finish_by_slot[ffisa_pkg::MAX_SLOTS];
      int unsigned             opened;
      ffisa_pkg::rsp_word_type owed_grants[$];
      int unsigned             errors;

      function new();
         foreach (finish_by_slot[k]) finish_by_slot[k] = '0;
         opened = 0;
         errors = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("ERROR: %s", msg);
      endfunction

      // First fit over the opened slots, else open a new slot while there is room.
      function void note_request(ffisa_pkg::req_word_type w);
         ffisa_pkg::finish_type   cand;
         ffisa_pkg::rsp_word_type r;
         bit                      hit;
         int unsigned             pick;
         int unsigned             k;
         cand = ffisa_pkg::finish_type'(w.start_minute) +
                ffisa_pkg::finish_type'(w.length_minutes);
         r = '0;
         hit = 1'b0;
         pick = 0;
         for (k = 0; k < opened && !hit; k++) begin
            if (finish_by_slot[k] <= ffisa_pkg::finish_type'(w.start_minute)) begin
               hit = 1'b1;
               pick = k;
            end
         end
         if (!hit && opened < ffisa_pkg::MAX_SLOTS) begin
            pick = opened;
            opened++;
            r.opened_new = 1'b1;
            hit = 1'b1;
         end
         if (hit) begin
            r.granted = 1'b1;
            r.slot_index = ffisa_pkg::slot_type'(pick);
            if (cand > finish_by_slot[pick]) finish_by_slot[pick] = cand;
         end
         owed_grants.push_back(r);
      endfunction

      // Compares one response word with the oldest owed grant.
      function void check_grant(ffisa_pkg::rsp_word_type got);
         ffisa_pkg::rsp_word_type want;
         if (owed_grants.size() == 0) begin
            flag($sformatf("unexpected response granted=%0d slot=%0d opened_new=%0d",
                           got.granted, got.slot_index, got.opened_new));
            return;
         end
         want = owed_grants.pop_front();
         if (got.granted !== want.granted || got.slot_index !== want.slot_index ||
             got.opened_new !== want.opened_new)
            flag($sformatf("granted %0d/%0d slot %0d/%0d opened_new %0d/%0d (exp/got)",
                           want.granted, got.granted, want.slot_index, got.slot_index,
                           want.opened_new, got.opened_new));
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   ffisa_pkg::req_word_type req_word;
   logic                    rsp_valid;
   logic                    rsp_stall;
   ffisa_pkg::rsp_word_type rsp_word;

   interval_grant_tracker grants;
   bit          calm;
   int unsigned cycles;

   first_fit_interval_slot_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle run length: mostly none or short, now and then long.
   function automatic int unsigned idle_length();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request word after an optional gap and holds it until taken.
   task automatic send_request(input int unsigned start, input int unsigned length);
      int unsigned gap;
      gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word.start_minute = start[ffisa_pkg::START_W-1:0];
      req_word.length_minutes = length[ffisa_pkg::LENGTH_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   // Response side back-pressure.
   initial begin : stall_driver
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && !reset) hold_left = idle_length();
         rsp_stall = (hold_left != 0);
         if (hold_left != 0) hold_left--;
      end
   end

   // Note every accepted request and check every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) grants.note_request(req_word);
         if (rsp_valid && !rsp_stall) grants.check_grant(rsp_word);
      end
   end

   // Watchdog.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("first_fit_interval_slot_allocator: mismatch");
      $finish;
   end

   initial begin : stimulus
      int unsigned cursor;
      int unsigned start;
      int unsigned length;
      int unsigned kind;
      int          n;
      grants = new();
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Opening slots from reset, zero duration, and reuse at the exact finish.
      send_request(0, 1);
      send_request(0, 0);
      send_request(0, 0);
      send_request(1, 4);
      send_request(3, 2);
      // Fill the whole table with the longest length, then get rejected.
      for (n = 0; n < ffisa_pkg::MAX_SLOTS; n++) send_request(10, 16383);
      send_request(20, 16383);
      send_request(16392, 0);
      send_request(16393, 1);
      send_request(16393, 0);

      // Mostly a forward-moving schedule, with some late, long or empty intervals.
      cursor = 16400;
      for (n = 0; n < 1200; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         cursor += $urandom_range(0, 200);
         if (cursor > 131071) cursor = 131071;
         kind = $urandom_range(0, 99);
         start = cursor;
         if (kind < 85) begin
            length = $urandom_range(1, 1500);
         end else if (kind < 92) begin
            length = $urandom_range(0, 16383);
         end else if (kind < 97) begin
            start = $urandom_range(0, cursor);
            length = $urandom_range(1, 300);
         end else begin
            length = 0;
         end
         send_request(start, length);
      end
      calm = 1'b0;

      // Top of the time range.
      send_request(131071, 16383);
      send_request(131071, 16383);
      send_request(131071, 0);
      @(negedge clock);
      req_valid = 1'b0;

      // Drain and let the pipeline settle.
      while (grants.owed_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (grants.owed_grants.size() != 0) grants.flag("responses still owed at the end");
      if (grants.errors == 0)
         $display("first_fit_interval_slot_allocator: match");
      else
         $display("first_fit_interval_slot_allocator: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
design/ffisa_pkg.sv
design/ffisa_pick.sv
design/first_fit_interval_slot_allocator.sv
design/ffisa_checker.sv
verif/tb.sv
